/* src/sic_pkg.sv */
// Shared widths, defaults and the square root result record.
`timescale 1ns / 1ps
package sic_pkg;

  localparam int SIDE_W = 17;
  localparam int POS_W  = 34;
  localparam int ROOT_W = 17;
  localparam int REM_W  = 20;
  localparam int MAX_SIDE_DEF = 131071;

  typedef struct packed {
    logic              vld;
    logic [ROOT_W-1:0] root;
    logic              exact;
    logic [POS_W-1:0]  pos;
    logic [SIDE_W-1:0] side;
  } sqrt_res_t;

endpackage

/* src/sic_sqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module sic_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [sic_pkg::SIDE_W-1:0]   in_side,
  input  logic [sic_pkg::POS_W-1:0]    in_pos,
  output sic_pkg::sqrt_res_t           res
);

  localparam int NS = sic_pkg::ROOT_W;

  logic                        vld_r  [NS];
  logic [sic_pkg::REM_W-1:0]   rem_r  [NS];
  logic [sic_pkg::ROOT_W-1:0]  root_r [NS];
  logic [sic_pkg::POS_W-1:0]   pos_r  [NS];
  logic [sic_pkg::SIDE_W-1:0]  side_r [NS];

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_stage
      logic [sic_pkg::REM_W-1:0]  prev_rem;
      logic [sic_pkg::ROOT_W-1:0] prev_root;
      logic [sic_pkg::POS_W-1:0]  prev_pos;
      logic [sic_pkg::SIDE_W-1:0] prev_side;
      logic                       prev_vld;
      logic [sic_pkg::REM_W-1:0]  cur;
      logic [sic_pkg::REM_W-1:0]  trial;
      logic                       ge;
      logic [sic_pkg::REM_W-1:0]  rem_nxt;
      logic [sic_pkg::ROOT_W-1:0] root_nxt;

      if (i == 0) begin : g_first
        assign prev_rem  = '0;
        assign prev_root = '0;
        assign prev_pos  = in_pos;
        assign prev_side = in_side;
        assign prev_vld  = in_vld;
      end else begin : g_next
        assign prev_rem  = rem_r[i-1];
        assign prev_root = root_r[i-1];
        assign prev_pos  = pos_r[i-1];
        assign prev_side = side_r[i-1];
        assign prev_vld  = vld_r[i-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign cur      = {prev_rem[sic_pkg::REM_W-3:0],
                         prev_pos[sic_pkg::POS_W-1-2*i -: 2]};
      assign trial    = {1'b0, prev_root, 2'b01};
      assign ge       = (cur >= trial);
      assign rem_nxt  = ge ? (cur - trial) : cur;
      assign root_nxt = {prev_root[sic_pkg::ROOT_W-2:0], ge};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= prev_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= rem_nxt;
          root_r[i] <= root_nxt;
          pos_r[i]  <= prev_pos;
          side_r[i] <= prev_side;
        end
      end
    end
  endgenerate

  assign res.vld   = vld_r[NS-1];
  assign res.root  = root_r[NS-1];
  assign res.exact = (rem_r[NS-1] == '0);
  assign res.pos   = pos_r[NS-1];
  assign res.side  = side_r[NS-1];

endmodule

/* src/sic_ring_map.sv */
// Ring side, offset split and coordinate stages after the square root.
`timescale 1ns / 1ps
module sic_ring_map #(
  parameter int MAX_SIDE = sic_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  sic_pkg::sqrt_res_t           sq,
  output logic                         out_vld,
  output logic [sic_pkg::SIDE_W-1:0]   out_line,
  output logic [sic_pkg::SIDE_W-1:0]   out_col,
  output logic                         out_bad
);

  localparam int SW = sic_pkg::SIDE_W;
  localparam int PW = sic_pkg::POS_W;

  // e1: ring side and side squared
  logic          e1_vld_r;
  logic [17:0]   e1_m_r;
  logic [PW-1:0] e1_ss_r, e1_pos_r;
  logic [SW-1:0] e1_side_r;
  logic [17:0]   m_nxt;

  always_comb begin
    if (sq.root[0]) begin
      m_nxt = sq.exact ? {1'b0, sq.root} : ({1'b0, sq.root} + 18'd2);
    end else begin
      m_nxt = {1'b0, sq.root} + 18'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_m_r    <= m_nxt;
      e1_ss_r   <= sq.side * sq.side;
      e1_pos_r  <= sq.pos;
      e1_side_r <= sq.side;
    end
  end

  // e2: inner ring area and request check
  logic          e2_vld_r, e2_bad_r, e2_one_r;
  logic [17:0]   e2_m_r;
  logic [35:0]   e2_sq_r;
  logic [PW-1:0] e2_pos_r;
  logic [SW-1:0] e2_side_r;
  logic [17:0]   mm2;
  logic          bad_nxt;

  assign mm2 = e1_m_r - 18'd2;
  assign bad_nxt = (e1_side_r == '0) || !e1_side_r[0] ||
                   ({15'b0, e1_side_r} > 32'(MAX_SIDE)) ||
                   (e1_pos_r == '0) || (e1_pos_r > e1_ss_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e2_m_r    <= e1_m_r;
      e2_sq_r   <= mm2 * mm2;
      e2_bad_r  <= bad_nxt;
      e2_one_r  <= (e1_pos_r == PW'(1));
      e2_pos_r  <= e1_pos_r;
      e2_side_r <= e1_side_r;
    end
  end

  // e3: offset into the ring
  logic          e3_vld_r, e3_bad_r, e3_one_r;
  logic [17:0]   e3_m_r;
  logic [19:0]   e3_off_r;
  logic [SW-1:0] e3_side_r;
  logic [PW-1:0] off_full;

  assign off_full = e2_pos_r - e2_sq_r[PW-1:0] - PW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      e3_m_r    <= e2_m_r;
      e3_off_r  <= off_full[19:0];
      e3_bad_r  <= e2_bad_r;
      e3_one_r  <= e2_one_r;
      e3_side_r <= e2_side_r;
    end
  end

  // e4: ring side index and position along it, ring shift
  logic          e4_vld_r, e4_bad_r, e4_one_r;
  logic [1:0]    e4_q_r;
  logic [17:0]   e4_r_r, e4_m_r;
  logic [SW-1:0] e4_h_r, e4_side_r;
  logic [19:0]   k1, k2, k3, sub;
  logic [1:0]    q_nxt;
  logic [19:0]   r_full;
  logic [17:0]   hd;

  assign k1 = {2'b0, e3_m_r - 18'd1};
  assign k2 = {k1[18:0], 1'b0};
  assign k3 = k2 + k1;

  always_comb begin
    if (e3_off_r >= k3) begin
      q_nxt = 2'd3; sub = k3;
    end else if (e3_off_r >= k2) begin
      q_nxt = 2'd2; sub = k2;
    end else if (e3_off_r >= k1) begin
      q_nxt = 2'd1; sub = k1;
    end else begin
      q_nxt = 2'd0; sub = '0;
    end
  end

  assign r_full = e3_off_r - sub;
  assign hd     = {1'b0, e3_side_r} - e3_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e4_q_r    <= q_nxt;
      e4_r_r    <= r_full[17:0];
      e4_h_r    <= hd[SW:1];
      e4_m_r    <= e3_m_r;
      e4_bad_r  <= e3_bad_r;
      e4_one_r  <= e3_one_r;
      e4_side_r <= e3_side_r;
    end
  end

  // e5: coordinates, output register
  logic          e5_vld_r, e5_bad_r;
  logic [SW-1:0] e5_line_r, e5_col_r;
  logic [17:0]   mh, h18, ln, cl;

  assign h18 = {1'b0, e4_h_r};
  assign mh  = e4_m_r + h18;

  always_comb begin
    case (e4_q_r)
      2'd0: begin
        ln = mh;
        cl = mh - 18'd1 - e4_r_r;
      end
      2'd1: begin
        ln = mh - 18'd1 - e4_r_r;
        cl = h18 + 18'd1;
      end
      2'd2: begin
        ln = h18 + 18'd1;
        cl = h18 + 18'd2 + e4_r_r;
      end
      default: begin
        ln = h18 + 18'd2 + e4_r_r;
        cl = mh;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e5_bad_r <= e4_bad_r;
      if (e4_bad_r) begin
        e5_line_r <= '0;
        e5_col_r  <= '0;
      end else if (e4_one_r) begin
        e5_line_r <= {1'b0, e4_side_r[SW-1:1]} + SW'(1);
        e5_col_r  <= {1'b0, e4_side_r[SW-1:1]} + SW'(1);
      end else begin
        e5_line_r <= ln[SW-1:0];
        e5_col_r  <= cl[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
      e5_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= sq.vld;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
      e4_vld_r <= e3_vld_r;
      e5_vld_r <= e4_vld_r;
    end
  end

  assign out_vld  = e5_vld_r;
  assign out_line = e5_line_r;
  assign out_col  = e5_col_r;
  assign out_bad  = e5_bad_r;

endmodule

/* src/spiral_index_to_coordinate.sv */
// Top level: square spiral position to grid line and column.
`timescale 1ns / 1ps
// Maps a 1-based position on a square spiral centered in an odd grid to its
// 1-based line and column. One transfer is accepted every cycle unless the
// output stalls; a result passes 17 square root stages, one per root bit,
// then five stages for ring side, ring area, offset, side split and
// coordinates. The whole pipe advances together whenever the
// output register is empty or being taken, so a stall on the result side
// holds every stage in place. An even or zero side, a side above MAX_SIDE,
// a zero position or a position beyond side squared gives bad_request = 1
// with zero coordinates.
module spiral_index_to_coordinate #(
  parameter int MAX_SIDE = sic_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [16:0] grid_side, [50:17] spiral_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [16:0] line, [33:17] column
  output logic        out_tuser   // [0] bad_request
);

  logic               en;
  sic_pkg::sqrt_res_t sq;
  logic [16:0]        line, column;
  logic               bad;

  // global advance: free when the output slot is empty or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  sic_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_side (in_tdata[16:0]),
    .in_pos  (in_tdata[50:17]),
    .res     (sq)
  );

  sic_ring_map #(
    .MAX_SIDE (MAX_SIDE)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .sq       (sq),
    .out_vld  (out_tvalid),
    .out_line (line),
    .out_col  (column),
    .out_bad  (bad)
  );

  assign out_tdata = {6'b0, column, line};
  assign out_tuser = bad;

endmodule

/* sim/spiral_index_to_coordinate_checker.sv */
// Checker: predicts spiral coordinates and compares each output transfer.
`timescale 1ns / 1ps
module spiral_index_to_coordinate_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending_count,
  output int          accepted_count
);

  typedef struct packed {
    logic [sic_pkg::SIDE_W-1:0] line;
    logic [sic_pkg::SIDE_W-1:0] column;
    logic                       bad_request;
  } coord_t;

  coord_t expected_coords[$];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 34;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic coord_t locate_cell(logic [sic_pkg::SIDE_W-1:0] side_in,
                                         logic [sic_pkg::POS_W-1:0] pos_in);
    coord_t c;
    logic [63:0] side, p, s, m, off, q, r, h, ln, col;
    side = 64'(side_in);
    p    = 64'(pos_in);
    c    = '0;
    if (side == 0 || side[0] == 1'b0 || side > 64'(sic_pkg::MAX_SIDE_DEF) || p == 0 ||
        p > side * side) begin
      c.bad_request = 1'b1;
    end else if (p == 1) begin
      ln       = (side + 1) / 2;
      c.line   = ln[sic_pkg::SIDE_W-1:0];
      c.column = ln[sic_pkg::SIDE_W-1:0];
    end else begin
      s = isqrt64(p);
      if (s[0]) m = (s * s == p) ? s : s + 2;
      else m = s + 1;
      off = p - ((m - 2) * (m - 2) + 1);
      q   = off / (m - 1);
      r   = off % (m - 1);
      h   = (side - m) / 2;
      case (q)
        0: begin ln = m + h;         col = m - 1 - r + h; end
        1: begin ln = m - 1 - r + h; col = 1 + h;         end
        2: begin ln = 1 + h;         col = 2 + r + h;     end
        default: begin ln = 2 + r + h; col = m + h; end
      endcase
      c.line   = ln[sic_pkg::SIDE_W-1:0];
      c.column = col[sic_pkg::SIDE_W-1:0];
    end
    return c;
  endfunction

  initial begin
    fail_count     = 0;
    accepted_count = 0;
  end
  assign pending_count = expected_coords.size();

  always @(posedge clk) begin
    coord_t exp_c, got;
    if (rst_n && in_tvalid && in_tready) begin
      expected_coords.push_back(locate_cell(in_tdata[16:0], in_tdata[50:17]));
      accepted_count <= accepted_count + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.line        = out_tdata[16:0];
      got.column      = out_tdata[33:17];
      got.bad_request = out_tuser;
      if (expected_coords.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10) $display("unexpected result %p", got);
      end else begin
        exp_c = expected_coords.pop_front();
        if (got !== exp_c) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("mismatch: expected %p got %p", exp_c, got);
        end
      end
    end
  end
endmodule

/* sim/tb_spiral_index_to_coordinate.sv */
// Testbench top: stimulus, handshake idling and final verdict.
`timescale 1ns / 1ps
module tb_spiral_index_to_coordinate;
  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  int          fail_count, pending_count, accepted_count;
  int          send_idle_pct, recv_stall_pct;
  int          idle_cycles;

  spiral_index_to_coordinate i_dut (.*);

  spiral_index_to_coordinate_checker i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid,
    .out_tready, .out_tdata, .out_tuser, .fail_count, .pending_count,
    .accepted_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random with the current phase's ratio.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_spiral_index_to_coordinate: errors");
        $finish;
      end
    end
  end

  // Drive one query; holds tvalid until the transfer.
  task automatic send_query(logic [16:0] side, logic [33:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, pos, side};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random side, mostly odd and small; position biased toward ring corners.
  task automatic send_random;
    logic [16:0] side;
    logic [33:0] pos, lim;
    logic [33:0] m;
    logic [63:0] wide;
    int k;
    k = $urandom_range(99);
    if (k < 8) side = 17'($urandom);
    else if (k < 12) side = 17'h1FFFF;
    else if (k < 70) side = 17'(($urandom_range(30) << 1) | 1);
    else side = 17'(($urandom_range(65535) << 1) | 1);
    lim = 34'(side) * 34'(side);
    k = $urandom_range(99);
    if (k < 8) begin
      wide = {$urandom, $urandom};
      pos  = wide[33:0];
    end else if (k < 12 || lim == 0) begin
      pos = lim + 34'($urandom_range(2));
    end else if (k < 40 && side > 2) begin
      m   = 34'(($urandom_range((side - 1) / 2) << 1) | 1);
      pos = m * m - 34'($urandom_range(3)) * (m - 34'd1) + 34'($urandom_range(2)) - 34'd1;
      if (pos == 0) pos = 34'd1;
    end else begin
      wide = {$urandom, $urandom};
      wide = (wide % 64'(lim)) + 64'd1;
      pos  = wide[33:0];
    end
    send_query(side, pos);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: center, corners, error cases, field extremes.
    send_query(17'd1, 34'd1);
    send_query(17'd1, 34'd2);
    send_query(17'd3, 34'd2);
    send_query(17'd3, 34'd3);
    send_query(17'd3, 34'd5);
    send_query(17'd3, 34'd7);
    send_query(17'd3, 34'd9);
    send_query(17'd3, 34'd10);
    send_query(17'd5, 34'd1);
    send_query(17'd5, 34'd10);
    send_query(17'd5, 34'd25);
    send_query(17'd4, 34'd3);
    send_query(17'd0, 34'd1);
    send_query(17'd7, 34'd0);
    send_query(17'h1FFFF, 34'd1);
    send_query(17'h1FFFF, 34'd17179607041);
    send_query(17'h1FFFF, 34'd17179607042);
    send_query(17'h1FFFF, 34'h3FFFFFFFF);
    send_query(17'h1FFFE, 34'd5);
    send_query(17'h1FFFF, 34'd17179344897);
    send_query(17'd9, 34'd49);
    send_query(17'd9, 34'd50);

    // Sender pauses until every expected result has come.
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);

    // Idling phases: none, sender, receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 32 : 0;
      repeat (320) send_random();
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d queries: directed corners and errors, random sides/positions",
             accepted_count);
    $display("four handshake idling phases, one drain pause");
    if (fail_count == 0) begin
      $display("tb_spiral_index_to_coordinate: clean");
    end else begin
      $display("tb_spiral_index_to_coordinate: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
src/sic_pkg.sv
src/sic_sqrt_pipe.sv
src/sic_ring_map.sv
src/spiral_index_to_coordinate.sv
sim/spiral_index_to_coordinate_checker.sv
sim/tb_spiral_index_to_coordinate.sv
